@@ src/tlik_pkg.sv @@
// Shared constants, types and tables for the two-link planar IK pipeline.
// No dependencies; used by every module but tlik_delay.
package tlik_pkg;

    localparam int COORD_BITS          = 11;
    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int LEN_W               = 10;
    localparam int LIMIT_W             = 11;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int D2_W    = 2 * COORD_BITS + 1;
    localparam int LSQ_W   = 2 * LEN_W;
    localparam int WIDE_W  = (D2_W > LSQ_W) ? D2_W : LSQ_W;
    localparam int COS_W   = WIDE_W + 2;
    localparam int CSQ_W   = 2 * (COS_W - 1);
    localparam int RAD_W   = 2 + LSQ_W + WIDE_W;
    localparam int SQ_W    = RAD_W + (RAD_W % 2);
    localparam int DIST_IN_W = D2_W + 8 + ((D2_W + 8) % 2);
    localparam int DIST_W  = 16;

    localparam int SH_W    = 17;
    localparam int EL_W    = 16;
    localparam int LO_W    = 17;

    localparam int ANG_W        = 26;
    localparam int NORM_MSB     = 38;
    localparam int CX_W         = NORM_MSB + 5;
    localparam int CORDIC_ITERS = 20;
    localparam int CORDIC_LAT   = CORDIC_ITERS + 4;

    localparam int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_W = SH_W + EL_W + LO_W + DIST_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REACH_LIMIT  = 2'd2;

    // degrees scaled by 2^16
    localparam logic signed [ANG_W-1:0] DEG90  = 26'sd5898240;
    localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;
    localparam logic signed [ANG_W-1:0] DEG360 = 26'sd23592960;

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic xzero;
        logic yzero;
    } t_quad;

    typedef struct packed {
        logic clamp;
        logic pos;
    } t_acos_sel;

    typedef struct packed {
        logic              reachable;
        logic [DIST_W-1:0] distance;
        logic [LO_W-1:0]   lower;
        logic [EL_W-1:0]   elbow;
        logic [SH_W-1:0]   shoulder;
    } t_result;

    function automatic logic signed [ANG_W-1:0] atan_tab(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:       v = 26'sd2949120;
            1:       v = 26'sd1740967;
            2:       v = 26'sd919879;
            3:       v = 26'sd466945;
            4:       v = 26'sd234379;
            5:       v = 26'sd117302;
            6:       v = 26'sd58666;
            7:       v = 26'sd29335;
            8:       v = 26'sd14668;
            9:       v = 26'sd7334;
            10:      v = 26'sd3667;
            11:      v = 26'sd1833;
            12:      v = 26'sd917;
            13:      v = 26'sd458;
            14:      v = 26'sd229;
            15:      v = 26'sd115;
            16:      v = 26'sd57;
            17:      v = 26'sd29;
            18:      v = 26'sd14;
            19:      v = 26'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ src/two_link_planar_ik.sv @@
// Two-link planar inverse kinematics: one request per cycle unless the output buffer is full.
// Results pass through the 23-stage square root feeding the 24-stage CORDIC atan2.
// A two-entry output buffer keeps intake running at one request per cycle while one result
// waits, and intake stops only when both entries are full.
// Reset clears the valid bits and the output buffer count and sets the link and reach registers
// to 100, 100 and 200. Depends on tlik_pkg, tlik_delay, tlik_isqrt and tlik_cordic.
module two_link_planar_ik #(
    parameter int ANGLE_FRAC_BITS = tlik_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tlik_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tlik_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // tdata, low bit up: base_x, base_y, target_x, target_y, zero fill
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tlik_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tdata, low bit up: shoulder_angle, elbow_angle, lower_link_angle, distance, zero fill
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [tlik_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // tuser: reachable
    output logic [0:0]                        m_axis_tuser
);
    import tlik_pkg::*;

    localparam int L_SQ       = SQ_W / 2;
    localparam int L_DIST     = DIST_IN_W / 2;
    localparam int ST_D2      = 3;
    localparam int ST_PREP    = 6;
    localparam int ST_COR_IN  = ST_PREP + L_SQ;
    localparam int ST_COR_OUT = ST_COR_IN + CORDIC_LAT;
    localparam int ST_LO      = ST_COR_OUT + 2;

    // configuration and derived constants
    logic [LEN_W-1:0]     r_upper_length, r_lower_length;
    logic [LIMIT_W-1:0]   r_reach_limit;
    logic [LSQ_W-1:0]     r_l1sq, r_l2sq, r_l1l2;
    logic [LSQ_W:0]       r_lsum;
    logic [2*LIMIT_W-1:0] r_rlsq;
    logic [RAD_W-1:0]     r_rel;
    logic [2*LSQ_W-1:0]   w_l1l2sq;

    // pipeline
    logic [ST_LO:1]            r_vld;
    logic                      w_en;
    logic [COORD_BITS-1:0]     w_bx, w_by, w_tx, w_ty;
    logic signed [DIFF_W-1:0]  r_dx1, r_dy1;
    logic signed [2*DIFF_W-1:0] w_dxsq, w_dysq;
    logic [D2_W-2:0]           r_dxsq2, r_dysq2;
    logic [D2_W-1:0]           r_d2;
    logic                      r_reach4;
    logic signed [COS_W-1:0]   r_csh4, r_cel4, r_csh5, r_cel5, r_csh6, r_cel6;
    logic [RAD_W-1:0]          r_rsh4, r_rsh5;
    logic [LSQ_W+D2_W-1:0]     w_rsh_p;
    logic [COS_W-1:0]          w_csh_mag, w_cel_mag;
    logic [CSQ_W-1:0]          r_cshsq5, r_celsq5, w_shdiff, w_eldiff;
    logic [SQ_W-1:0]           r_shdiff6, r_eldiff6;
    t_acos_sel                 r_shsel6, r_elsel6, w_shsel, w_elsel;
    logic [SQ_W/2-1:0]         w_sh_root, w_el_root;
    logic [COS_W-1:0]          w_csh_dl, w_cel_dl;
    logic [2*DIFF_W-1:0]       w_base_dl;
    logic signed [ANG_W-1:0]   w_cor_sh, w_cor_el, w_cor_base;
    logic signed [ANG_W-1:0]   r_sh54, r_el54, r_sh55, r_el55, r_lo55, n_sh54, n_el54, n_lo55;
    logic                      w_reach_dl;
    logic [L_DIST-1:0]         w_dist_root, w_dist_dl;

    // output buffer
    t_result    r_head, r_skid, w_res;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    function automatic logic [ANG_W-1:0] round_ang(input logic signed [ANG_W-1:0] z);
        logic [ANG_W-1:0] mag, r;
        mag = z[ANG_W-1] ? -z : z;
        r   = (mag + ANG_W'(1 << (15 - ANGLE_FRAC_BITS))) >> (16 - ANGLE_FRAC_BITS);
        return z[ANG_W-1] ? -r : r;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_length <= LEN_W'(100);
            r_lower_length <= LEN_W'(100);
            r_reach_limit  <= LIMIT_W'(200);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_UPPER_LENGTH: r_upper_length <= i_cfg_data[LEN_W-1:0];
                CFG_LOWER_LENGTH: r_lower_length <= i_cfg_data[LEN_W-1:0];
                CFG_REACH_LIMIT:  r_reach_limit  <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_l1l2sq = r_l1l2 * r_l1l2;

    // follow the registers; they settle well before a request reaches them
    always_ff @(posedge i_clk) begin
        r_l1sq <= r_upper_length * r_upper_length;
        r_l2sq <= r_lower_length * r_lower_length;
        r_l1l2 <= r_upper_length * r_lower_length;
        r_rlsq <= r_reach_limit * r_reach_limit;
        r_lsum <= (LSQ_W+1)'(r_l1sq) + (LSQ_W+1)'(r_l2sq);
        r_rel  <= RAD_W'({w_l1l2sq, 2'b00});
    end

    assign w_en          = (r_cnt != 2'd2);
    assign s_axis_tready = w_en;

    assign w_bx = s_axis_tdata[COORD_BITS-1:0];
    assign w_by = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign w_tx = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign w_ty = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];

    always_comb begin
        w_dxsq  = r_dx1 * r_dx1;
        w_dysq  = r_dy1 * r_dy1;
        w_rsh_p = r_l1sq * r_d2;
        w_csh_mag = r_csh4[COS_W-1] ? -r_csh4 : r_csh4;
        w_cel_mag = r_cel4[COS_W-1] ? -r_cel4 : r_cel4;
        w_shdiff  = CSQ_W'(r_rsh5) - r_cshsq5;
        w_eldiff  = CSQ_W'(r_rel) - r_celsq5;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[ST_LO-1:1], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx1   <= signed'({1'b0, w_tx}) - signed'({1'b0, w_bx});
            r_dy1   <= signed'({1'b0, w_by}) - signed'({1'b0, w_ty});
            r_dxsq2 <= w_dxsq[D2_W-2:0];
            r_dysq2 <= w_dysq[D2_W-2:0];
            r_d2    <= D2_W'(r_dxsq2) + D2_W'(r_dysq2);
            r_reach4 <= (r_d2 != '0) && (r_d2 < D2_W'(r_rlsq));
            r_csh4  <= signed'(COS_W'(r_l1sq)) + signed'(COS_W'(r_d2))
                       - signed'(COS_W'(r_l2sq));
            r_cel4  <= signed'(COS_W'(r_lsum)) - signed'(COS_W'(r_d2));
            r_rsh4  <= RAD_W'({w_rsh_p, 2'b00});
            r_csh5  <= r_csh4;
            r_cel5  <= r_cel4;
            r_rsh5  <= r_rsh4;
            r_cshsq5 <= w_csh_mag[COS_W-2:0] * w_csh_mag[COS_W-2:0];
            r_celsq5 <= w_cel_mag[COS_W-2:0] * w_cel_mag[COS_W-2:0];
            r_csh6  <= r_csh5;
            r_cel6  <= r_cel5;
            r_shdiff6 <= w_shdiff[SQ_W-1:0];
            r_eldiff6 <= w_eldiff[SQ_W-1:0];
            // clamp the cosine when |c| reaches the radius
            r_shsel6.clamp <= (r_cshsq5 >= CSQ_W'(r_rsh5));
            r_shsel6.pos   <= ~r_csh5[COS_W-1];
            r_elsel6.clamp <= (r_celsq5 >= CSQ_W'(r_rel));
            r_elsel6.pos   <= ~r_cel5[COS_W-1];
            r_sh54  <= n_sh54;
            r_el54  <= n_el54;
            r_sh55  <= r_sh54;
            r_el55  <= r_el54;
            r_lo55  <= n_lo55;
        end
    end

    tlik_isqrt #(.IW(SQ_W)) u_sqrt_sh (
        .i_clk(i_clk), .i_en(w_en), .i_value(r_shdiff6), .o_root(w_sh_root)
    );

    tlik_isqrt #(.IW(SQ_W)) u_sqrt_el (
        .i_clk(i_clk), .i_en(w_en), .i_value(r_eldiff6), .o_root(w_el_root)
    );

    tlik_isqrt #(.IW(DIST_IN_W)) u_sqrt_dist (
        .i_clk(i_clk), .i_en(w_en), .i_value(DIST_IN_W'({r_d2, 8'd0})),
        .o_root(w_dist_root)
    );

    tlik_delay #(.W(COS_W), .DEPTH(L_SQ)) u_dl_csh (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_csh6), .o_q(w_csh_dl)
    );

    tlik_delay #(.W(COS_W), .DEPTH(L_SQ)) u_dl_cel (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_cel6), .o_q(w_cel_dl)
    );

    tlik_delay #(.W(2*DIFF_W), .DEPTH(ST_COR_IN-1)) u_dl_base (
        .i_clk(i_clk), .i_en(w_en), .i_d({r_dy1, r_dx1}), .o_q(w_base_dl)
    );

    tlik_delay #(.W($bits(t_acos_sel)), .DEPTH(ST_COR_OUT-ST_PREP)) u_dl_shsel (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_shsel6), .o_q(w_shsel)
    );

    tlik_delay #(.W($bits(t_acos_sel)), .DEPTH(ST_COR_OUT-ST_PREP)) u_dl_elsel (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_elsel6), .o_q(w_elsel)
    );

    tlik_delay #(.W(1), .DEPTH(ST_LO-4)) u_dl_reach (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_reach4), .o_q(w_reach_dl)
    );

    tlik_delay #(.W(L_DIST), .DEPTH(ST_LO-ST_D2-L_DIST)) u_dl_dist (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_dist_root), .o_q(w_dist_dl)
    );

    tlik_cordic #(.IW(COS_W)) u_cordic_sh (
        .i_clk(i_clk), .i_en(w_en), .i_y(COS_W'(w_sh_root)), .i_x(w_csh_dl),
        .o_z(w_cor_sh)
    );

    tlik_cordic #(.IW(COS_W)) u_cordic_el (
        .i_clk(i_clk), .i_en(w_en), .i_y(COS_W'(w_el_root)), .i_x(w_cel_dl),
        .o_z(w_cor_el)
    );

    tlik_cordic #(.IW(DIFF_W)) u_cordic_base (
        .i_clk(i_clk), .i_en(w_en), .i_y(w_base_dl[2*DIFF_W-1:DIFF_W]),
        .i_x(w_base_dl[DIFF_W-1:0]), .o_z(w_cor_base)
    );

    always_comb begin
        logic signed [ANG_W-1:0] ash, t;
        if (w_shsel.clamp) begin
            ash = w_shsel.pos ? '0 : DEG180;
        end else begin
            ash = w_cor_sh;
        end
        n_sh54 = ash + w_cor_base;
        if (n_sh54 > DEG180) begin
            n_sh54 = n_sh54 - DEG360;
        end
        if (w_elsel.clamp) begin
            n_el54 = w_elsel.pos ? '0 : DEG180;
        end else begin
            n_el54 = w_cor_el;
        end
        t      = r_sh54 + r_el54;
        n_lo55 = DEG180 - t;
        if (n_lo55 > DEG180) begin
            n_lo55 = n_lo55 - DEG360;
        end
    end

    always_comb begin
        logic [ANG_W-1:0] sh, el, lo;
        sh = round_ang(r_sh55);
        el = round_ang(r_el55);
        lo = round_ang(r_lo55);
        w_res.reachable = w_reach_dl;
        w_res.distance  = DIST_W'(w_dist_dl);
        // drop the angles for a target out of reach
        w_res.shoulder  = w_reach_dl ? sh[SH_W-1:0] : '0;
        w_res.elbow     = w_reach_dl ? el[EL_W-1:0] : '0;
        w_res.lower     = w_reach_dl ? lo[LO_W-1:0] : '0;
    end

    assign w_push = w_en && r_vld[ST_LO];
    assign w_pop  = (r_cnt != 2'd0) && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && !w_push) begin
            r_head <= r_skid;
        end else if (w_push && w_pop) begin
            r_head <= w_res;
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_head <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign m_axis_tvalid   = (r_cnt != 2'd0);
    assign m_axis_tuser[0] = r_head.reachable;
    assign m_axis_tdata    = OUT_TDATA_W'({r_head.distance, r_head.lower,
                                           r_head.elbow, r_head.shoulder});

endmodule

@@ src/tlik_delay.sv @@
// Enable-gated shift line that keeps side data in step with the pipeline.
// No package dependencies.
module tlik_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

@@ src/tlik_isqrt.sv @@
// Pipelined floor square root, one result bit per stage, IW/2 stages.
// Default width from tlik_pkg.
module tlik_isqrt #(
    parameter int IW = tlik_pkg::SQ_W
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [IW-1:0]   i_value,
    output logic [IW/2-1:0] o_root
);

    localparam int N   = IW / 2;
    localparam int RMW = N + 2;

    logic [RMW-1:0] r_rem  [N];
    logic [N-1:0]   r_root [N];
    logic [IW-1:0]  r_val  [N];
    logic [RMW-1:0] n_rem  [N];
    logic [N-1:0]   n_root [N];
    logic [IW-1:0]  n_val  [N];

    always_comb begin
        logic [RMW-1:0] pr;
        logic [N-1:0]   pt;
        logic [IW-1:0]  pv;
        logic [RMW+1:0] rs;
        logic [RMW+1:0] trial;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                pr = '0;
                pt = '0;
                pv = i_value;
            end else begin
                pr = r_rem[k-1];
                pt = r_root[k-1];
                pv = r_val[k-1];
            end
            rs    = {pr, pv[IW-1 -: 2]};
            trial = (RMW+2)'({pt, 2'b01});
            if (rs >= trial) begin
                n_rem[k]  = RMW'(rs - trial);
                n_root[k] = {pt[N-2:0], 1'b1};
            end else begin
                n_rem[k]  = RMW'(rs);
                n_root[k] = {pt[N-2:0], 1'b0};
            end
            n_val[k] = pv << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_val[k]  <= n_val[k];
            end
        end
    end

    assign o_root = r_root[N-1];

endmodule

@@ src/tlik_cordic.sv @@
// Pipelined vectoring CORDIC atan2 in degrees * 2^16, result in [-180, 180].
// Uses constants, the arctangent table and t_quad from tlik_pkg.
module tlik_cordic #(
    parameter int IW = tlik_pkg::COS_W
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [IW-1:0]               i_y,
    input  logic signed [IW-1:0]               i_x,
    output logic signed [tlik_pkg::ANG_W-1:0]  o_z
);
    import tlik_pkg::*;

    localparam int NW    = NORM_MSB + 1;
    localparam int SHA_W = $clog2(NW);

    logic [IW-1:0]          r_ax1, r_ay1, r_ax2, r_ay2;
    t_quad                  r_q1, r_q2;
    logic [SHA_W-1:0]       r_sha;
    logic signed [CX_W-1:0] r_cx [CORDIC_ITERS+1];
    logic signed [CX_W-1:0] r_cy [CORDIC_ITERS+1];
    logic signed [ANG_W-1:0] r_z [CORDIC_ITERS+1];
    t_quad                  r_q  [CORDIC_ITERS+1];
    logic signed [CX_W-1:0] n_cx [CORDIC_ITERS+1];
    logic signed [CX_W-1:0] n_cy [CORDIC_ITERS+1];
    logic signed [ANG_W-1:0] n_z [CORDIC_ITERS+1];
    logic signed [ANG_W-1:0] r_zo;

    logic [IW-1:0]           w_ax, w_ay, w_m;
    t_quad                   w_q;
    logic [SHA_W-1:0]        w_msb, w_sha;
    logic signed [ANG_W-1:0] n_zo;

    always_comb begin
        w_ax = i_x[IW-1] ? -i_x : i_x;
        w_ay = i_y[IW-1] ? -i_y : i_y;
        w_q.xneg  = i_x[IW-1];
        w_q.yneg  = i_y[IW-1];
        w_q.xzero = (i_x == '0);
        w_q.yzero = (i_y == '0);
    end

    // shift so the larger magnitude lands on the normalising bit
    always_comb begin
        w_m   = r_ax1 | r_ay1;
        w_msb = '0;
        for (int b = 0; b < IW; b++) begin
            if (w_m[b]) begin
                w_msb = SHA_W'(b);
            end
        end
        w_sha = SHA_W'(NORM_MSB) - w_msb;
    end

    always_comb begin
        logic signed [CX_W-1:0] sx, sy;
        n_cx[0] = '0;
        n_cy[0] = '0;
        n_z[0]  = '0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            sx = r_cx[i] >>> i;
            sy = r_cy[i] >>> i;
            if (!r_cy[i][CX_W-1]) begin
                n_cx[i+1] = r_cx[i] + sy;
                n_cy[i+1] = r_cy[i] - sx;
                n_z[i+1]  = r_z[i] + atan_tab(i);
            end else begin
                n_cx[i+1] = r_cx[i] - sy;
                n_cy[i+1] = r_cy[i] + sx;
                n_z[i+1]  = r_z[i] - atan_tab(i);
            end
        end
    end

    always_comb begin
        t_quad q;
        q    = r_q[CORDIC_ITERS];
        n_zo = r_z[CORDIC_ITERS];
        if (n_zo[ANG_W-1]) begin
            n_zo = '0;
        end else if (n_zo > DEG90) begin
            n_zo = DEG90;
        end
        if (q.xzero) begin
            n_zo = DEG90;
        end else if (q.yzero) begin
            n_zo = '0;
        end
        if (q.xneg) begin
            n_zo = DEG180 - n_zo;
        end
        if (q.yneg) begin
            n_zo = -n_zo;
        end
        if (q.xzero && q.yzero) begin
            n_zo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax1 <= w_ax;
            r_ay1 <= w_ay;
            r_q1  <= w_q;
            r_ax2 <= r_ax1;
            r_ay2 <= r_ay1;
            r_q2  <= r_q1;
            r_sha <= w_sha;
            r_cx[0] <= signed'(CX_W'(NW'(r_ax2) << r_sha));
            r_cy[0] <= signed'(CX_W'(NW'(r_ay2) << r_sha));
            r_z[0]  <= n_z[0];
            r_q[0]  <= r_q2;
            for (int i = 1; i <= CORDIC_ITERS; i++) begin
                r_cx[i] <= n_cx[i];
                r_cy[i] <= n_cy[i];
                r_z[i]  <= n_z[i];
                r_q[i]  <= r_q[i-1];
            end
            r_zo <= n_zo;
        end
    end

    assign o_z = r_zo;

endmodule
